### rtl/core/scrp_pkg.sv
// Shared types and constants for the SOCKS connect request parser.
// Holds the phase encoding, result kinds and the run descriptor format.
// No dependencies.
package scrp_pkg;

  localparam logic [1:0] IN_BYTE    = 2'd0;
  localparam logic [1:0] IN_END     = 2'd1;
  localparam logic [1:0] IN_OUTCOME = 2'd2;

  localparam logic [2:0] OK_REPLY   = 3'd0;
  localparam logic [2:0] OK_ADDR    = 3'd1;
  localparam logic [2:0] OK_CONNECT = 3'd2;
  localparam logic [2:0] OK_RELAY   = 3'd3;
  localparam logic [2:0] OK_CLOSE   = 3'd4;
  localparam logic [2:0] OK_ABORT   = 3'd5;
  localparam logic [2:0] OK_END     = 3'd6;

  localparam logic [1:0] AT_IPV4   = 2'd0;
  localparam logic [1:0] AT_DOMAIN = 2'd1;
  localparam logic [1:0] AT_IPV6   = 2'd2;

  localparam logic [7:0] ST4_OK       = 8'h5A;
  localparam logic [7:0] ST4_REJECT   = 8'h5B;
  localparam logic [7:0] ST5_OK       = 8'h00;
  localparam logic [7:0] ST5_FAIL     = 8'h01;
  localparam logic [7:0] ST5_REFUSED  = 8'h05;
  localparam logic [7:0] ST5_BAD_CMD  = 8'h07;
  localparam logic [7:0] ST5_BAD_ATYP = 8'h08;
  localparam logic [7:0] VER5         = 8'h05;
  localparam logic [7:0] NO_METHOD    = 8'hFF;
  localparam logic [7:0] CMD_CONNECT  = 8'h01;

  localparam logic [15:0] MAX_NAME_RESET = 16'd4096;

  typedef enum logic [4:0] {
    PH_VER, PH4_CMD, PH4_PORT, PH4_IP, PH4_USER, PH4_DOM, PH4_WAIT, PH4_WAITE,
    PH5_NMETH, PH5_METH, PH5_HDR, PH5_HDRBAD, PH5_DLEN, PH5_ADDR, PH5_PORT,
    PH5_WAIT, PH5_WAITE, PH_RELAY, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    R_NONE, R_ONE, R_REP4, R_REP5, R_METH, R_CONN4
  } run_t;

  typedef struct packed {
    run_t        rtype;
    logic [2:0]  okind;
    logic [7:0]  data;
    logic        cl;
    logic [15:0] port;
    logic [1:0]  at;
    logic [31:0] ipv4;
  } desc_t;

endpackage

### rtl/core/scrp_parser.sv
// Protocol state of the request parser: one client item per cycle while take is high.
// Produces at most one run descriptor per item. Depends on scrp_pkg.
module scrp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                take,
  input  logic [1:0]          kind,
  input  logic [7:0]          in_byte,
  input  logic                connect_ok,
  output scrp_pkg::desc_t     desc
);
  import scrp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  command_code, command_code_next;
  logic [7:0]  remaining_count, remaining_count_next;
  logic        no_auth_seen, no_auth_seen_next;
  logic [31:0] ipv4_hold, ipv4_hold_next;
  logic [15:0] port_hold, port_hold_next;
  logic [1:0]  addr_kind, addr_kind_next;
  logic [15:0] name_length, name_length_next;
  logic [15:0] max_name_length;
  logic [7:0]  dec;
  logic        name_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length <= MAX_NAME_RESET;
    end else if (cfg_wr_en) begin
      max_name_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_VER;
      command_code    <= '0;
      remaining_count <= '0;
      no_auth_seen    <= 1'b0;
      ipv4_hold       <= '0;
      port_hold       <= '0;
      addr_kind       <= '0;
      name_length     <= '0;
    end else if (take) begin
      phase           <= phase_next;
      command_code    <= command_code_next;
      remaining_count <= remaining_count_next;
      no_auth_seen    <= no_auth_seen_next;
      ipv4_hold       <= ipv4_hold_next;
      port_hold       <= port_hold_next;
      addr_kind       <= addr_kind_next;
      name_length     <= name_length_next;
    end
  end

  assign dec     = remaining_count - 8'd1;
  assign name_ok = name_length < max_name_length;

  always_comb begin
    phase_next           = phase;
    command_code_next    = command_code;
    remaining_count_next = remaining_count;
    no_auth_seen_next    = no_auth_seen;
    ipv4_hold_next       = ipv4_hold;
    port_hold_next       = port_hold;
    addr_kind_next       = addr_kind;
    name_length_next     = name_length;
    desc       = '0;
    desc.rtype = R_NONE;
    case (phase)
      PH_VER: begin
        if (kind == IN_BYTE) begin
          if (in_byte == 8'd4) begin
            phase_next = PH4_CMD;
          end else if (in_byte == 8'd5) begin
            phase_next = PH5_NMETH;
          end else begin
            desc.rtype = R_ONE;
            desc.okind = OK_CLOSE;
            phase_next = PH_DONE;
          end
        end else if (kind == IN_END) begin
          desc.rtype = R_ONE;
          desc.okind = OK_ABORT;
          phase_next = PH_DONE;
        end
      end
      PH4_CMD, PH4_PORT, PH4_IP, PH4_USER, PH4_DOM: begin
        if (kind == IN_END) begin
          desc.rtype = R_REP4;
          desc.data  = ST4_REJECT;
          desc.cl    = 1'b1;
          phase_next = PH_DONE;
        end else if (kind == IN_BYTE) begin
          case (phase)
            PH4_CMD: begin
              command_code_next    = in_byte;
              remaining_count_next = 8'd2;
              port_hold_next       = '0;
              phase_next           = PH4_PORT;
            end
            PH4_PORT: begin
              port_hold_next       = {port_hold[7:0], in_byte};
              remaining_count_next = dec;
              if (dec == 8'd0) begin
                remaining_count_next = 8'd4;
                ipv4_hold_next       = '0;
                phase_next           = PH4_IP;
              end
            end
            PH4_IP: begin
              ipv4_hold_next       = {ipv4_hold[23:0], in_byte};
              remaining_count_next = dec;
              if (dec == 8'd0) begin
                name_length_next = '0;
                phase_next       = PH4_USER;
              end
            end
            default: begin
              if (in_byte != 8'd0) begin
                if (!name_ok) begin
                  desc.rtype = R_REP4;
                  desc.data  = ST4_REJECT;
                  desc.cl    = 1'b1;
                  phase_next = PH_DONE;
                end else begin
                  name_length_next = name_length + 16'd1;
                  if (phase == PH4_DOM) begin
                    desc.rtype = R_ONE;
                    desc.okind = OK_ADDR;
                    desc.data  = in_byte;
                  end
                end
              end else if (phase == PH4_USER && ipv4_hold[31:8] == 24'd0 &&
                           ipv4_hold[7:0] != 8'd0) begin
                name_length_next = '0;
                addr_kind_next   = AT_DOMAIN;
                phase_next       = PH4_DOM;
              end else begin
                if (phase == PH4_USER) begin
                  addr_kind_next = AT_IPV4;
                end
                if (command_code != CMD_CONNECT) begin
                  desc.rtype = R_REP4;
                  desc.data  = ST4_REJECT;
                  desc.cl    = 1'b1;
                  phase_next = PH_DONE;
                end else begin
                  desc.port  = port_hold;
                  desc.ipv4  = ipv4_hold;
                  phase_next = PH4_WAIT;
                  if (phase == PH4_USER) begin
                    desc.rtype = R_CONN4;
                    desc.at    = AT_IPV4;
                  end else begin
                    desc.rtype = R_ONE;
                    desc.okind = OK_CONNECT;
                    desc.at    = addr_kind;
                  end
                end
              end
            end
          endcase
        end
      end
      PH4_WAIT, PH5_WAIT, PH4_WAITE, PH5_WAITE: begin
        if (kind == IN_BYTE && (phase == PH4_WAIT || phase == PH5_WAIT)) begin
          desc.rtype = R_ONE;
          desc.okind = OK_RELAY;
          desc.data  = in_byte;
        end else if (kind == IN_END && (phase == PH4_WAIT || phase == PH5_WAIT)) begin
          desc.rtype = R_ONE;
          desc.okind = OK_END;
          phase_next = (phase == PH4_WAIT) ? PH4_WAITE : PH5_WAITE;
        end else if (kind == IN_OUTCOME) begin
          desc.cl = !connect_ok;
          if (phase == PH4_WAIT || phase == PH4_WAITE) begin
            desc.rtype = R_REP4;
            desc.data  = connect_ok ? ST4_OK : ST4_REJECT;
          end else begin
            desc.rtype = R_REP5;
            desc.data  = connect_ok ? ST5_OK : ST5_REFUSED;
          end
          if (connect_ok && (phase == PH4_WAIT || phase == PH5_WAIT)) begin
            phase_next = PH_RELAY;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      PH5_NMETH, PH5_METH: begin
        if (kind == IN_END) begin
          desc.rtype = R_ONE;
          desc.okind = OK_ABORT;
          phase_next = PH_DONE;
        end else if (kind == IN_BYTE) begin
          if (phase == PH5_NMETH) begin
            if (in_byte == 8'd0) begin
              desc.rtype = R_METH;
              desc.data  = NO_METHOD;
              desc.cl    = 1'b1;
              phase_next = PH_DONE;
            end else begin
              remaining_count_next = in_byte;
              no_auth_seen_next    = 1'b0;
              phase_next           = PH5_METH;
            end
          end else begin
            no_auth_seen_next    = no_auth_seen | (in_byte == 8'd0);
            remaining_count_next = dec;
            if (dec == 8'd0) begin
              desc.rtype = R_METH;
              if (no_auth_seen_next) begin
                desc.data            = ST5_OK;
                remaining_count_next = '0;
                phase_next           = PH5_HDR;
              end else begin
                desc.data  = NO_METHOD;
                desc.cl    = 1'b1;
                phase_next = PH_DONE;
              end
            end
          end
        end
      end
      PH5_HDR, PH5_HDRBAD: begin
        if (kind == IN_END) begin
          desc.rtype = R_REP5;
          desc.data  = ST5_FAIL;
          desc.cl    = 1'b1;
          phase_next = PH_DONE;
        end else if (kind == IN_BYTE) begin
          if (remaining_count > 8'd2) begin
            if (phase == PH5_HDRBAD) begin
              desc.rtype = R_REP5;
              desc.data  = ST5_FAIL;
              desc.cl    = 1'b1;
              phase_next = PH_DONE;
            end else if (in_byte == 8'd1) begin
              addr_kind_next       = AT_IPV4;
              remaining_count_next = 8'd4;
              phase_next           = PH5_ADDR;
            end else if (in_byte == 8'd3) begin
              addr_kind_next = AT_DOMAIN;
              phase_next     = PH5_DLEN;
            end else if (in_byte == 8'd4) begin
              addr_kind_next       = AT_IPV6;
              remaining_count_next = 8'd16;
              phase_next           = PH5_ADDR;
            end else begin
              desc.rtype = R_REP5;
              desc.data  = ST5_BAD_ATYP;
              desc.cl    = 1'b1;
              phase_next = PH_DONE;
            end
          end else begin
            remaining_count_next = remaining_count + 8'd1;
            if (remaining_count == 8'd0 && in_byte != VER5) begin
              phase_next = PH5_HDRBAD;
            end
            if (remaining_count == 8'd1) begin
              command_code_next = in_byte;
            end
            if (remaining_count == 8'd2 && in_byte != 8'd0) begin
              phase_next = PH5_HDRBAD;
            end
          end
        end
      end
      PH5_DLEN, PH5_ADDR, PH5_PORT: begin
        if (kind == IN_END) begin
          desc.rtype = R_REP5;
          desc.data  = ST5_BAD_ATYP;
          desc.cl    = 1'b1;
          phase_next = PH_DONE;
        end else if (kind == IN_BYTE) begin
          if (phase == PH5_DLEN) begin
            if (in_byte == 8'd0) begin
              desc.rtype = R_REP5;
              desc.data  = ST5_BAD_ATYP;
              desc.cl    = 1'b1;
              phase_next = PH_DONE;
            end else begin
              remaining_count_next = in_byte;
              phase_next           = PH5_ADDR;
            end
          end else if (phase == PH5_ADDR) begin
            desc.rtype           = R_ONE;
            desc.okind           = OK_ADDR;
            desc.data            = in_byte;
            remaining_count_next = dec;
            if (dec == 8'd0) begin
              remaining_count_next = 8'd2;
              port_hold_next       = '0;
              phase_next           = PH5_PORT;
            end
          end else begin
            port_hold_next       = {port_hold[7:0], in_byte};
            remaining_count_next = dec;
            if (dec == 8'd0) begin
              if (command_code != CMD_CONNECT) begin
                desc.rtype = R_REP5;
                desc.data  = ST5_BAD_CMD;
                desc.cl    = 1'b1;
                phase_next = PH_DONE;
              end else begin
                desc.rtype = R_ONE;
                desc.okind = OK_CONNECT;
                desc.port  = {port_hold[7:0], in_byte};
                desc.at    = addr_kind;
                phase_next = PH5_WAIT;
              end
            end
          end
        end
      end
      PH_RELAY: begin
        if (kind == IN_BYTE) begin
          desc.rtype = R_ONE;
          desc.okind = OK_RELAY;
          desc.data  = in_byte;
        end else if (kind == IN_END) begin
          desc.rtype = R_ONE;
          desc.okind = OK_END;
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/scrp_run_queue.sv
// Two-entry queue of run descriptors between the parser and the emitter.
// Depends on scrp_pkg.
module scrp_run_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scrp_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            full,
  output logic            nonempty,
  output scrp_pkg::desc_t head
);
  import scrp_pkg::*;

  desc_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign head     = mem[rd_ptr];

endmodule

### rtl/core/scrp_emitter.sv
// Expands the run descriptor at the head of the queue into result transfers.
// Depends on scrp_pkg.
module scrp_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            have,
  input  scrp_pkg::desc_t head,
  input  logic            out_stall,
  output logic            pop,
  output logic            out_valid,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [15:0]     target_port,
  output logic [1:0]      address_type,
  output logic            close_after,
  output logic            last
);
  import scrp_pkg::*;

  logic [3:0] idx;
  logic [3:0] final_idx;

  always_comb begin
    out_kind     = OK_REPLY;
    out_byte     = '0;
    target_port  = '0;
    address_type = '0;
    close_after  = 1'b0;
    final_idx    = 4'd0;
    case (head.rtype)
      R_ONE: begin
        out_kind = head.okind;
        if (head.okind == OK_CONNECT) begin
          target_port  = head.port;
          address_type = head.at;
        end else begin
          out_byte = head.data;
        end
      end
      R_REP4: begin
        final_idx   = 4'd7;
        out_byte    = (idx == 4'd1) ? head.data : 8'h00;
        close_after = head.cl && idx == 4'd7;
      end
      R_REP5: begin
        final_idx   = 4'd9;
        close_after = head.cl && idx == 4'd9;
        case (idx)
          4'd0:    out_byte = VER5;
          4'd1:    out_byte = head.data;
          4'd3:    out_byte = 8'h01;
          default: out_byte = 8'h00;
        endcase
      end
      R_METH: begin
        final_idx   = 4'd1;
        out_byte    = (idx == 4'd0) ? VER5 : head.data;
        close_after = head.cl && idx == 4'd1;
      end
      R_CONN4: begin
        final_idx = 4'd4;
        out_kind  = OK_ADDR;
        case (idx)
          4'd0:    out_byte = head.ipv4[31:24];
          4'd1:    out_byte = head.ipv4[23:16];
          4'd2:    out_byte = head.ipv4[15:8];
          4'd3:    out_byte = head.ipv4[7:0];
          default: begin
            out_kind     = OK_CONNECT;
            target_port  = head.port;
            address_type = head.at;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign out_valid = have;
  assign last      = idx == final_idx;
  assign pop       = have && !out_stall && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (have && !out_stall) begin
      idx <= last ? 4'd0 : idx + 4'd1;
    end
  end

endmodule

### rtl/core/socks_connect_request_parser.sv
// Top level of the SOCKS4/4a/5 connect request parser.
// Instantiates scrp_parser, scrp_run_queue and scrp_emitter; uses scrp_pkg.
//
//   Channel  Signals                                    Direction
//   in       in_valid, in_stall, kind, in_byte, connect_ok    in
//   out      out_valid, out_stall, out_kind .. last           out
//   cfg      cfg_wr_en, cfg_wr_data (max_name_length)   in
//
// An input transfer is parsed in its accept cycle; its run of 0 to 10 results
// is queued and leaves at one result per cycle while out_stall is low.
// Input is taken every cycle while the two-entry run queue has room, so the
// output run length sets the sustained rate. Reset is synchronous; the queue
// empties and the parser waits for a version byte. Result stalls hold the
// current result and fill the queue, which then stalls the input.
module socks_connect_request_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  in_byte,
  input  logic        connect_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] target_port,
  output logic [1:0]  address_type,
  output logic        close_after,
  output logic        last
);
  import scrp_pkg::*;

  desc_t desc, head;
  logic  take, full, nonempty, pop;

  assign in_stall = full;
  assign take     = in_valid && !full;

  scrp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .kind        (kind),
    .in_byte     (in_byte),
    .connect_ok  (connect_ok),
    .desc        (desc)
  );

  scrp_run_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take && desc.rtype != R_NONE),
    .push_desc (desc),
    .pop       (pop),
    .full      (full),
    .nonempty  (nonempty),
    .head      (head)
  );

  scrp_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .have         (nonempty),
    .head         (head),
    .out_stall    (out_stall),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .target_port  (target_port),
    .address_type (address_type),
    .close_after  (close_after),
    .last         (last)
  );

endmodule
